>>> sv/qpia_pkg.sv
package qpia_pkg;

  // pixel positions per group, impulse slots per pixel, 16-bit channels per word
  localparam int unsigned NumPos   = 4;
  localparam int unsigned NumSlot  = 4;
  localparam int unsigned NumChan  = 8;
  localparam int unsigned ChanW    = 16;
  localparam int unsigned WordW    = NumChan * ChanW;
  localparam int unsigned HalfW    = WordW / 2;
  localparam int unsigned ColorW   = 8;
  localparam int unsigned PosW     = $clog2(NumPos);
  localparam int unsigned SlotW    = $clog2(NumSlot);
  localparam int unsigned AddrW    = ColorW + PosW + SlotW;
  localparam int unsigned BankDepth = 2 ** ColorW;
  localparam int unsigned FlushLen = NumSlot - 1;
  localparam int unsigned FlushW   = $clog2(NumSlot);

  // stream packing
  localparam int unsigned InDataW  = 176;
  localparam int unsigned OutDataW = WordW;

  typedef logic [WordW-1:0] word_t;

  // command carried in tuser
  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdGroup = 1'b1
  } cmd_e;

  // one impulse table write toward a lane
  typedef struct packed {
    logic              en;
    logic [SlotW-1:0]  slot;
    logic [ColorW-1:0] addr;
    word_t             data;
  } tbl_wr_t;

  // group control travelling beside the data
  typedef struct packed {
    logic valid;
    logic last;
  } grp_ctl_t;

  // eight independent 16-bit wrapping additions
  function automatic word_t chan_add(word_t a, word_t b);
    word_t r;
    r = '0;
    for (int unsigned k = 0; k < NumChan; k++) begin
      r[k*ChanW +: ChanW] = a[k*ChanW +: ChanW] + b[k*ChanW +: ChanW];
    end
    return r;
  endfunction

endpackage

>>> sv/qpia_lane.sv
module qpia_lane
  import qpia_pkg::*;
(
  input  logic               clk_i,
  input  tbl_wr_t            wr_i,
  input  logic               rd_en_i,
  input  logic [ColorW-1:0]  color_i,
  output word_t              words_o [NumSlot]
);

  // one bank per slot, addressed by color code
  for (genvar s = 0; s < NumSlot; s++) begin : g_bank
    word_t bank_mem [BankDepth];
    word_t rd_q;

    // table load
    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.slot == SlotW'(s))) begin
        bank_mem[wr_i.addr] <= wr_i.data;
      end
    end

    // registered read, held while the next stage stalls
    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        rd_q <= bank_mem[color_i];
      end
    end

    assign words_o[s] = rd_q;
  end

endmodule

>>> sv/qpia_merge.sv
module qpia_merge
  import qpia_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  grp_ctl_t ctl_i,
  input  word_t    words_i [NumPos][NumSlot],
  output grp_ctl_t ctl_o,
  output word_t    sums_o [NumSlot]
);

  grp_ctl_t ctl_q;
  word_t    sum_d [NumSlot];
  word_t    sum_q [NumSlot];

  // combine the four pixel lanes per slot
  always_comb begin
    for (int unsigned s = 0; s < NumSlot; s++) begin
      sum_d[s] = chan_add(chan_add(words_i[0][s], words_i[1][s]),
                          chan_add(words_i[2][s], words_i[3][s]));
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  // slot sum register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign sums_o = sum_q;

endmodule

>>> sv/quad_pixel_impulse_accumulator.sv
// Overlap-add impulse filter for video artifact synthesis. A load transaction (tuser 0) writes
// one 128-bit impulse word at index color*16 + 4*position + slot; the table sits in sixteen
// 256-entry banks, one per position and slot, so all sixteen words of a pixel group are read
// in the same cycle. A group transaction (tuser 1) passes the bank read, merge and output
// registers in that order; groups are taken one per cycle as long as the output is taken and
// no flush is running. A group with tlast set returns four vectors, the group result and
// the three pending sums, tlast on the fourth; the output register drains these in turn,
// and the pending sums are zero afterwards. Table words are undefined until loaded; a group
// must only read loaded entries.
module quad_pixel_impulse_accumulator
  import qpia_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // table_index[11:0], table_word_low[75:12], table_word_high[139:76],
  // pixel_a[147:140], pixel_b[155:148], pixel_c[163:156], pixel_d[171:164], zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // command
  input  logic                s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // sum_low[63:0], sum_high[127:64]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  localparam int unsigned WordLo = AddrW;
  localparam int unsigned PixLo  = AddrW + WordW;

  logic                accept;
  logic                is_group;
  logic                en0, en1, en2;
  logic                out_free;
  logic [AddrW-1:0]    tbl_index;
  tbl_wr_t             wr_lane [NumPos];
  word_t               lane_words [NumPos][NumSlot];
  grp_ctl_t            ctl1_d, ctl1_q, ctl2;
  word_t               slot_sums [NumSlot];
  word_t               acc [NumSlot];
  word_t               pend_q [FlushLen];
  logic [FlushW-1:0]   flush_cnt_q;
  logic                out_valid_q;
  word_t               out_data_q;
  logic                out_last_q;

  // handshake and stage enables
  assign out_free      = !out_valid_q || m_axis_tready;
  assign en2           = out_free && (flush_cnt_q == '0);
  assign en1           = !ctl2.valid || en2;
  assign en0           = !ctl1_q.valid || en1;
  assign s_axis_tready = en0;
  assign accept        = s_axis_tvalid && en0;
  assign is_group      = (cmd_e'(s_axis_tuser) == CmdGroup);
  assign tbl_index     = s_axis_tdata[AddrW-1:0];

  // lanes, one per pixel position
  for (genvar p = 0; p < NumPos; p++) begin : g_lane
    always_comb begin
      wr_lane[p].en   = accept && !is_group &&
                        (tbl_index[SlotW +: PosW] == PosW'(p));
      wr_lane[p].slot = tbl_index[SlotW-1:0];
      wr_lane[p].addr = tbl_index[SlotW+PosW +: ColorW];
      wr_lane[p].data = s_axis_tdata[WordLo +: WordW];
    end

    qpia_lane u_lane (
      .clk_i   (clk_i),
      .wr_i    (wr_lane[p]),
      .rd_en_i (accept && is_group),
      .color_i (s_axis_tdata[PixLo + p*ColorW +: ColorW]),
      .words_o (lane_words[p])
    );
  end

  // first stage control beside the bank reads
  always_comb begin
    ctl1_d.valid = accept && is_group;
    ctl1_d.last  = s_axis_tlast;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (en0) begin
      ctl1_q <= ctl1_d;
    end
  end

  // merge the lanes per slot
  qpia_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .ctl_i   (ctl1_q),
    .words_i (lane_words),
    .ctl_o   (ctl2),
    .sums_o  (slot_sums)
  );

  // add the pending partial sums
  always_comb begin
    for (int unsigned s = 0; s < FlushLen; s++) begin
      acc[s] = chan_add(pend_q[s], slot_sums[s]);
    end
    acc[FlushLen] = slot_sums[FlushLen];
  end

  // accumulator, flush counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned s = 0; s < FlushLen; s++) begin
        pend_q[s] <= '0;
      end
      flush_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else if (flush_cnt_q != '0) begin
      if (out_free) begin
        for (int unsigned s = 0; s + 1 < FlushLen; s++) begin
          pend_q[s] <= pend_q[s+1];
        end
        pend_q[FlushLen-1] <= '0;
        flush_cnt_q        <= flush_cnt_q - 1'b1;
        out_valid_q        <= 1'b1;
      end
    end else if (out_free) begin
      if (ctl2.valid) begin
        for (int unsigned s = 0; s < FlushLen; s++) begin
          pend_q[s] <= acc[s+1];
        end
        flush_cnt_q <= ctl2.last ? FlushW'(FlushLen) : '0;
        out_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (flush_cnt_q != '0) begin
      if (out_free) begin
        out_data_q <= pend_q[0];
        out_last_q <= (flush_cnt_q == FlushW'(1));
      end
    end else if (out_free && ctl2.valid) begin
      out_data_q <= acc[0];
      out_last_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // line end appears only once the flush has run out
  a_last_after_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (flush_cnt_q == '0))
    else $error("line end shown while flush still pending");

  // pending sums are cleared once line end is shown
  a_pend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |->
      ((pend_q[0] == '0) && (pend_q[1] == '0) && (pend_q[2] == '0)))
    else $error("pending sums not cleared at line end");

  // a flush always has a vector in the output register
  a_flush_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_cnt_q != '0) |-> out_valid_q)
    else $error("flush running with empty output register");

endmodule
